// ===== rtl/ics_pkg.sv =====
package ics_pkg;

  // Reset values of the configuration registers
  localparam logic        BAND_SELECT_RST     = 1'b0;
  localparam logic [7:0]  QUIET_THRESHOLD_RST = 8'd0;
  localparam logic [7:0]  LIMIT_LEVEL_RST     = 8'd255;
  localparam logic        LIMIT_RUN_MODE_RST  = 1'b0;
  localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd120;
  localparam logic [5:0]  MAX_ATTEN_RST       = 6'd30;
  localparam logic [5:0]  ATTEN_WIN_LOW_RST   = 6'd0;
  localparam logic [5:0]  ATTEN_WIN_HIGH_RST  = 6'd63;

  // Gain and alarm constants
  localparam logic [7:0] GAIN_LOW_BAND   = 8'd70;
  localparam logic [7:0] GAIN_HIGH_BAND  = 8'd75;
  localparam logic [7:0] OFFSET_CAP      = 8'd62;
  localparam logic [7:0] ALARM_BASE_LOW  = 8'd74;
  localparam logic [7:0] ALARM_BASE_HIGH = 8'd77;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_STEP  = 3'd2,
    PH_LIMIT = 3'd3,
    PH_OK    = 3'd4,
    PH_FAIL  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    MSG_CHECKING  = 3'd0,
    MSG_LIMIT     = 3'd1,
    MSG_LIMIT_RUN = 3'd2,
    MSG_OK        = 3'd3,
    MSG_FAIL      = 3'd4
  } msg_e;

  typedef enum logic [1:0] {
    AMP_NONE    = 2'd0,
    AMP_RX_ON   = 2'd1,
    AMP_ALL_ON  = 2'd2,
    AMP_ALL_OFF = 2'd3
  } amp_e;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_POWERUP = 2'd1,
    FUNC_RECHECK = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_SELECT     = 3'd0,
    CFG_QUIET_THRESHOLD = 3'd1,
    CFG_LIMIT_LEVEL     = 3'd2,
    CFG_LIMIT_RUN_MODE  = 3'd3,
    CFG_TIMEOUT_TICKS   = 3'd4,
    CFG_MAX_ATTEN       = 3'd5,
    CFG_ATTEN_WIN_LOW   = 3'd6,
    CFG_ATTEN_WIN_HIGH  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        band_select;
    logic [7:0]  quiet_threshold;
    logic [7:0]  limit_level;
    logic        limit_run_mode;
    logic [15:0] timeout_ticks;
    logic [5:0]  max_atten;
    logic [5:0]  atten_window_low;
    logic [5:0]  atten_window_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_power;
    logic       check_enable;
  } in_t;

  typedef struct packed {
    logic [2:0] check_state;
    logic [2:0] message;
    logic       atten_write;
    logic [5:0] atten_value;
    logic [1:0] amp_command;
    logic       alarm_write;
    logic       alarm_fail;
    logic [7:0] alarm_level;
    logic [7:0] measured_isolation;
    logic [7:0] gain_out;
  } out_t;

  // Check sequencer state carried from one item to the next
  typedef struct packed {
    phase_e      phase;
    logic        powerup_pending;
    logic        recheck_pending;
    logic [5:0]  atten_now;
    logic [7:0]  gain_now;
    logic [7:0]  isolation_now;
    logic [15:0] timeout_count;
    logic        timer_running;
    msg_e        msg_now;
  } seq_st_t;

endpackage

// ===== rtl/ics_cfg.sv =====
module ics_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [ics_pkg::CFG_IDX_W-1:0]   wr_idx_i,
  input  logic [ics_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output ics_pkg::cfg_t                   cfg_o
);

  ics_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (ics_pkg::cfg_idx_e'(wr_idx_i))
        ics_pkg::CFG_BAND_SELECT:     cfg_d.band_select       = wr_data_i[0];
        ics_pkg::CFG_QUIET_THRESHOLD: cfg_d.quiet_threshold   = wr_data_i[7:0];
        ics_pkg::CFG_LIMIT_LEVEL:     cfg_d.limit_level       = wr_data_i[7:0];
        ics_pkg::CFG_LIMIT_RUN_MODE:  cfg_d.limit_run_mode    = wr_data_i[0];
        ics_pkg::CFG_TIMEOUT_TICKS:   cfg_d.timeout_ticks     = wr_data_i[15:0];
        ics_pkg::CFG_MAX_ATTEN:       cfg_d.max_atten         = wr_data_i[5:0];
        ics_pkg::CFG_ATTEN_WIN_LOW:   cfg_d.atten_window_low  = wr_data_i[5:0];
        ics_pkg::CFG_ATTEN_WIN_HIGH:  cfg_d.atten_window_high = wr_data_i[5:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_select       <= ics_pkg::BAND_SELECT_RST;
      cfg_q.quiet_threshold   <= ics_pkg::QUIET_THRESHOLD_RST;
      cfg_q.limit_level       <= ics_pkg::LIMIT_LEVEL_RST;
      cfg_q.limit_run_mode    <= ics_pkg::LIMIT_RUN_MODE_RST;
      cfg_q.timeout_ticks     <= ics_pkg::TIMEOUT_TICKS_RST;
      cfg_q.max_atten         <= ics_pkg::MAX_ATTEN_RST;
      cfg_q.atten_window_low  <= ics_pkg::ATTEN_WIN_LOW_RST;
      cfg_q.atten_window_high <= ics_pkg::ATTEN_WIN_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ics_step.sv =====
module ics_step #(
  parameter logic [7:0] GainLowBand   = ics_pkg::GAIN_LOW_BAND,
  parameter logic [7:0] GainHighBand  = ics_pkg::GAIN_HIGH_BAND,
  parameter logic [7:0] OffsetCap     = ics_pkg::OFFSET_CAP,
  parameter logic [7:0] AlarmBaseLow  = ics_pkg::ALARM_BASE_LOW,
  parameter logic [7:0] AlarmBaseHigh = ics_pkg::ALARM_BASE_HIGH
) (
  input  ics_pkg::cfg_t    cfg_i,
  input  ics_pkg::in_t     item_i,
  input  ics_pkg::seq_st_t st_i,
  output ics_pkg::seq_st_t st_o,
  output ics_pkg::out_t    res_o
);

  logic [7:0] band_gain;
  logic [7:0] alarm_base;
  logic [8:0] gain_sum;
  logic [7:0] iso_new;
  logic [7:0] gain_new;
  logic [8:0] ref_sum;
  logic [7:0] offset;
  logic [7:0] offset_capped;

  assign band_gain  = cfg_i.band_select ? GainHighBand : GainLowBand;
  assign alarm_base = cfg_i.band_select ? AlarmBaseHigh : AlarmBaseLow;

  // End-of-check gain: isolation is half of gain plus attenuation
  assign gain_sum = {1'b0, st_i.gain_now} + {3'b000, st_i.atten_now};
  assign iso_new  = gain_sum[8:1];
  assign gain_new = gain_sum[7:0] - {2'b00, cfg_i.max_atten};

  // Limit alarm offset from the expected isolation, capped
  assign ref_sum       = {1'b0, band_gain} + {3'b000, cfg_i.max_atten};
  assign offset        = ref_sum[8:1] - iso_new;
  assign offset_capped = (offset > OffsetCap) ? OffsetCap : offset;

  always_comb begin
    ics_pkg::phase_e ph;
    logic            fin;

    st_o = st_i;
    ph   = st_i.phase;
    fin  = 1'b0;
    res_o.atten_write = 1'b0;
    res_o.amp_command = ics_pkg::AMP_NONE;
    res_o.alarm_write = 1'b0;
    res_o.alarm_fail  = 1'b0;
    res_o.alarm_level = '0;

    unique case (item_i.func)
      ics_pkg::FUNC_POWERUP: begin
        st_o.powerup_pending = 1'b1;
        st_o.phase           = ics_pkg::PH_IDLE;
      end
      ics_pkg::FUNC_RECHECK: begin
        st_o.recheck_pending = 1'b1;
        st_o.phase           = ics_pkg::PH_IDLE;
      end
      ics_pkg::FUNC_TICK: begin
        // timer counts down on every tick while running, armed or not
        if (st_i.timer_running && (st_i.timeout_count != '0)) begin
          st_o.timeout_count = st_i.timeout_count - 16'd1;
        end
        if (item_i.check_enable && (st_i.powerup_pending || st_i.recheck_pending)) begin
          if ((ph != ics_pkg::PH_IDLE) && st_i.timer_running &&
              (st_o.timeout_count == '0)) begin
            ph = ics_pkg::PH_FAIL;
          end
          st_o.phase = ph;
          unique case (ph)
            ics_pkg::PH_IDLE: begin
              st_o.timeout_count = cfg_i.timeout_ticks;
              st_o.timer_running = 1'b1;
              st_o.phase         = ics_pkg::PH_WAIT;
              st_o.msg_now       = ics_pkg::MSG_CHECKING;
              st_o.gain_now      = band_gain;
            end
            ics_pkg::PH_WAIT: begin
              if (item_i.rx_power < cfg_i.quiet_threshold) begin
                res_o.amp_command = ics_pkg::AMP_RX_ON;
                res_o.atten_write = 1'b1;
                st_o.atten_now    = cfg_i.max_atten;
                st_o.phase        = ics_pkg::PH_STEP;
                st_o.msg_now      = ics_pkg::MSG_CHECKING;
              end
            end
            ics_pkg::PH_STEP: begin
              if (item_i.rx_power >= cfg_i.limit_level) begin
                if ((st_i.atten_now > cfg_i.atten_window_high) ||
                    (st_i.atten_now < cfg_i.atten_window_low)) begin
                  st_o.phase = ics_pkg::PH_FAIL;
                end else begin
                  st_o.phase = ics_pkg::PH_LIMIT;
                end
              end else if (st_i.atten_now == 6'd0) begin
                st_o.phase = ics_pkg::PH_OK;
              end else if (st_i.atten_now == 6'd1) begin
                res_o.atten_write = 1'b1;
                st_o.atten_now    = 6'd0;
              end else begin
                res_o.atten_write = 1'b1;
                st_o.atten_now    = st_i.atten_now - 6'd2;
              end
            end
            ics_pkg::PH_LIMIT: begin
              fin                = 1'b1;
              st_o.isolation_now = iso_new;
              st_o.gain_now      = gain_new;
              res_o.amp_command  = ics_pkg::AMP_ALL_OFF;
              st_o.msg_now       = cfg_i.limit_run_mode ? ics_pkg::MSG_LIMIT_RUN
                                                        : ics_pkg::MSG_LIMIT;
              res_o.alarm_write  = 1'b1;
              res_o.alarm_level  = alarm_base + offset_capped;
            end
            ics_pkg::PH_OK: begin
              fin                = 1'b1;
              st_o.isolation_now = iso_new;
              st_o.gain_now      = gain_new;
              res_o.amp_command  = ics_pkg::AMP_ALL_ON;
              st_o.msg_now       = ics_pkg::MSG_OK;
              res_o.alarm_write  = 1'b1;
              res_o.alarm_level  = AlarmBaseHigh;
            end
            ics_pkg::PH_FAIL: begin
              fin               = 1'b1;
              res_o.amp_command = ics_pkg::AMP_ALL_OFF;
              st_o.msg_now      = ics_pkg::MSG_FAIL;
              res_o.alarm_write = 1'b1;
              res_o.alarm_fail  = 1'b1;
            end
            default: st_o.phase = ics_pkg::PH_IDLE;
          endcase
          // end phases park the attenuator and disarm the check
          if (fin) begin
            res_o.atten_write    = 1'b1;
            st_o.atten_now       = cfg_i.max_atten;
            st_o.powerup_pending = 1'b0;
            st_o.recheck_pending = 1'b0;
            st_o.timer_running   = 1'b0;
            st_o.timeout_count   = '0;
          end
        end
      end
      default: st_o = st_i;
    endcase

    res_o.check_state        = st_o.phase;
    res_o.message            = st_o.msg_now;
    res_o.atten_value        = st_o.atten_now;
    res_o.measured_isolation = st_o.isolation_now;
    res_o.gain_out           = st_o.gain_now;
  end

endmodule

// ===== rtl/isolation_check_sequencer.sv =====
// Isolation check sequencer. Each input item is a one-second tick carrying the
// measured output power, or a power-up start / recheck request that restarts
// the check. Every accepted item returns exactly one result item: phase,
// message, attenuator write, amplifier command, alarm value, isolation and
// gain. Items are taken one per clock cycle unless the result register stalls;
// a result is offered once its item has moved from the input register through
// the combinational step logic into the output register. The output register
// lets the next item be taken while a result waits for the consumer. The check
// state updates in the same cycle an item is processed, so consecutive items
// chain without bubbles.
// Configuration registers are written through the cfg port (always ready) and
// must only change while no item is in flight.
module isolation_check_sequencer #(
  parameter logic [7:0] GainLowBand   = ics_pkg::GAIN_LOW_BAND,
  parameter logic [7:0] GainHighBand  = ics_pkg::GAIN_HIGH_BAND,
  parameter logic [7:0] OffsetCap     = ics_pkg::OFFSET_CAP,
  parameter logic [7:0] AlarmBaseLow  = ics_pkg::ALARM_BASE_LOW,
  parameter logic [7:0] AlarmBaseHigh = ics_pkg::ALARM_BASE_HIGH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ics_pkg::in_t                    in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ics_pkg::out_t                   out_data_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ics_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ics_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ics_pkg::cfg_t    cfg;
  ics_pkg::in_t     in_q;
  logic             in_valid_q;
  ics_pkg::out_t    out_q, res;
  logic             out_valid_q;
  ics_pkg::seq_st_t st_q, st_d;
  logic             step_fire;

  assign cfg_ready_o = 1'b1;

  ics_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The stored item advances when the result register is free or being drained
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  ics_step #(
    .GainLowBand   (GainLowBand),
    .GainHighBand  (GainHighBand),
    .OffsetCap     (OffsetCap),
    .AlarmBaseLow  (AlarmBaseLow),
    .AlarmBaseHigh (AlarmBaseHigh)
  ) u_step (
    .cfg_i  (cfg),
    .item_i (in_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Sequencer state commits only when an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase           <= ics_pkg::PH_IDLE;
      st_q.powerup_pending <= 1'b1;
      st_q.recheck_pending <= 1'b0;
      st_q.atten_now       <= ics_pkg::MAX_ATTEN_RST;
      st_q.gain_now        <= '0;
      st_q.isolation_now   <= '0;
      st_q.timeout_count   <= '0;
      st_q.timer_running   <= 1'b0;
      st_q.msg_now         <= ics_pkg::MSG_CHECKING;
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stopped timer always sits at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.timer_running |-> (st_q.timeout_count == '0))
    else $error("timer stopped with nonzero count");

  // A failure alarm is only issued from the fail phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alarm_fail) |->
      (out_q.check_state == ics_pkg::PH_FAIL) && out_q.alarm_write)
    else $error("fail alarm outside fail phase");

  // Every alarm parks the attenuator at its maximum and disarms the check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && res.alarm_write) |=>
      out_q.atten_write && (out_q.atten_value == cfg.max_atten) &&
      !st_q.powerup_pending && !st_q.recheck_pending)
    else $error("alarm issued without parking attenuator");

  // A stalled result and the sequencer state hold until the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q) && $stable(st_q))
    else $error("result or state changed under stall");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ics_pkg::*;

  // func code 3 has no meaning; the block must leave everything alone
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // how a phase picks its register values
  localparam int unsigned CFG_MIX      = 0;
  localparam int unsigned CFG_ALL_LOW  = 1;
  localparam int unsigned CFG_ALL_HIGH = 2;

  localparam int unsigned HOLD_CYCLES   = 400; // long consumer stall, fills the pipe
  localparam int unsigned ITEMS_PER_RUN = 122; // minimum live items per random phase
  localparam int unsigned MAX_PRINTS    = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  isolation_check_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copy plus sequencer state, both at reset.
  // ---------------------------------------------------------------------------
  cfg_t regs = '{BAND_SELECT_RST, QUIET_THRESHOLD_RST, LIMIT_LEVEL_RST,
                 LIMIT_RUN_MODE_RST, TIMEOUT_TICKS_RST, MAX_ATTEN_RST,
                 ATTEN_WIN_LOW_RST, ATTEN_WIN_HIGH_RST};

  phase_e      ph         = PH_IDLE;
  logic        pend_pwrup = 1'b1;   // power-up check armed out of reset
  logic        pend_rechk = 1'b0;
  logic [5:0]  att        = MAX_ATTEN_RST;
  logic [7:0]  gain       = 8'd0;
  logic [7:0]  iso        = 8'd0;
  logic [15:0] tmr_cnt    = 16'd0;
  logic        tmr_run    = 1'b0;
  msg_e        msg        = MSG_CHECKING;

  in_t  request_q[$];   // items waiting for the sender
  out_t status_q[$];    // predicted results, oldest first

  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 46;
  logic        hold_go     = 1'b0;
  logic        rx_hold     = 1'b0;
  logic        in_taken    = 1'b0;
  int unsigned fail_count  = 0;
  int unsigned live_items  = 0;

  function automatic logic [7:0] band_gain();
    return regs.band_select ? GAIN_HIGH_BAND : GAIN_LOW_BAND;
  endfunction

  // end of check: isolation is half of gain + attenuation (9-bit sum),
  // gain keeps the sum less the parking attenuation
  function automatic void settle_gain();
    logic [8:0] sum;
    sum  = {1'b0, gain} + {3'b0, att};
    iso  = sum[8:1];
    gain = 8'(sum - {3'b0, regs.max_atten});
  endfunction

  // every end phase parks the attenuator and disarms the check
  function automatic void park_and_disarm();
    att        = regs.max_atten;
    pend_pwrup = 1'b0;
    pend_rechk = 1'b0;
    tmr_run    = 1'b0;
    tmr_cnt    = 16'd0;
  endfunction

  // One item in, one status out; updates the shadow state.
  function automatic out_t advance_check(input in_t it);
    out_t        r;
    int unsigned span;
    logic [7:0]  off;
    r = '0;
    case (it.func)
      FUNC_POWERUP: begin
        pend_pwrup = 1'b1;
        ph = PH_IDLE;
      end
      FUNC_RECHECK: begin
        pend_rechk = 1'b1;
        ph = PH_IDLE;
      end
      FUNC_TICK: begin
        // timer runs on every tick, enabled or not
        if (tmr_run && tmr_cnt != 16'd0) tmr_cnt = tmr_cnt - 16'd1;
        if (it.check_enable && (pend_pwrup || pend_rechk)) begin
          if (ph != PH_IDLE && tmr_run && tmr_cnt == 16'd0) ph = PH_FAIL;
          case (ph)
            PH_IDLE: begin
              tmr_cnt = regs.timeout_ticks;
              tmr_run = 1'b1;
              ph      = PH_WAIT;
              msg     = MSG_CHECKING;
              gain    = band_gain();
            end
            PH_WAIT: begin
              if (it.rx_power < regs.quiet_threshold) begin
                r.amp_command = AMP_RX_ON;
                att           = regs.max_atten;
                r.atten_write = 1'b1;
                ph            = PH_STEP;
                msg           = MSG_CHECKING;
              end
            end
            PH_STEP: begin
              if (it.rx_power >= regs.limit_level) begin
                if (att > regs.atten_window_high || att < regs.atten_window_low)
                  ph = PH_FAIL;
                else
                  ph = PH_LIMIT;
              end else if (att == 6'd0) begin
                ph = PH_OK;
              end else begin
                att           = (att == 6'd1) ? 6'd0 : att - 6'd2;
                r.atten_write = 1'b1;
              end
            end
            PH_LIMIT: begin
              settle_gain();
              r.amp_command = AMP_ALL_OFF;
              park_and_disarm();
              r.atten_write = 1'b1;
              msg  = regs.limit_run_mode ? MSG_LIMIT_RUN : MSG_LIMIT;
              span = ((band_gain() + regs.max_atten) >> 1) - iso;
              off  = span[7:0];
              if (off > OFFSET_CAP) off = OFFSET_CAP;
              r.alarm_write = 1'b1;
              r.alarm_level = (regs.band_select ? ALARM_BASE_HIGH : ALARM_BASE_LOW) + off;
            end
            PH_OK: begin
              settle_gain();
              r.amp_command = AMP_ALL_ON;
              park_and_disarm();
              r.atten_write = 1'b1;
              msg           = MSG_OK;
              r.alarm_write = 1'b1;
              r.alarm_level = ALARM_BASE_HIGH;
            end
            PH_FAIL: begin
              r.amp_command = AMP_ALL_OFF;
              park_and_disarm();
              r.atten_write = 1'b1;
              msg           = MSG_FAIL;
              r.alarm_write = 1'b1;
              r.alarm_fail  = 1'b1;
            end
            default: ph = PH_IDLE;
          endcase
        end
      end
      default: ;  // unused func code
    endcase
    r.check_state        = ph;
    r.message            = msg;
    r.atten_value        = att;
    r.measured_isolation = iso;
    r.gain_out           = gain;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MAX_PRINTS)
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drives at the falling edge, holds the item until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus the long hold-off when armed
  always @(negedge clk_i) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long hold-off, counted on its own; the sender keeps offering meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge. Results are checked before the new
  // prediction is queued so a same-edge accept can never match itself.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result, check_state", out_data.check_state, 0);
        end else begin
          want = status_q.pop_front();
          if (out_data.check_state !== want.check_state)
            report_mismatch("check_state", out_data.check_state, want.check_state);
          if (out_data.message !== want.message)
            report_mismatch("message", out_data.message, want.message);
          if (out_data.atten_write !== want.atten_write)
            report_mismatch("atten_write", out_data.atten_write, want.atten_write);
          if (out_data.atten_value !== want.atten_value)
            report_mismatch("atten_value", out_data.atten_value, want.atten_value);
          if (out_data.amp_command !== want.amp_command)
            report_mismatch("amp_command", out_data.amp_command, want.amp_command);
          if (out_data.alarm_write !== want.alarm_write)
            report_mismatch("alarm_write", out_data.alarm_write, want.alarm_write);
          if (out_data.alarm_fail !== want.alarm_fail)
            report_mismatch("alarm_fail", out_data.alarm_fail, want.alarm_fail);
          if (out_data.alarm_level !== want.alarm_level)
            report_mismatch("alarm_level", out_data.alarm_level, want.alarm_level);
          if (out_data.measured_isolation !== want.measured_isolation)
            report_mismatch("measured_isolation", out_data.measured_isolation,
                            want.measured_isolation);
          if (out_data.gain_out !== want.gain_out)
            report_mismatch("gain_out", out_data.gain_out, want.gain_out);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) status_q.push_back(advance_check(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_BAND_SELECT:     regs.band_select       = val[0];
      CFG_QUIET_THRESHOLD: regs.quiet_threshold   = val[7:0];
      CFG_LIMIT_LEVEL:     regs.limit_level       = val[7:0];
      CFG_LIMIT_RUN_MODE:  regs.limit_run_mode    = val[0];
      CFG_TIMEOUT_TICKS:   regs.timeout_ticks     = val[15:0];
      CFG_MAX_ATTEN:       regs.max_atten         = val[5:0];
      CFG_ATTEN_WIN_LOW:   regs.atten_window_low  = val[5:0];
      CFG_ATTEN_WIN_HIGH:  regs.atten_window_high = val[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input int unsigned band, quiet, limit, run_mode,
                           tmo, max_att, win_lo, win_hi);
    write_reg(CFG_BAND_SELECT, band);
    write_reg(CFG_QUIET_THRESHOLD, quiet);
    write_reg(CFG_LIMIT_LEVEL, limit);
    write_reg(CFG_LIMIT_RUN_MODE, run_mode);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    write_reg(CFG_MAX_ATTEN, max_att);
    write_reg(CFG_ATTEN_WIN_LOW, win_lo);
    write_reg(CFG_ATTEN_WIN_HIGH, win_hi);
  endtask

  // mostly a typical value, now and then an extreme one; an all-low or all-high bias always gives that extreme
  function automatic int unsigned pick(input int unsigned lo, hi, typ_lo, typ_hi,
                                       input int unsigned bias);
    int unsigned roll;
    roll = $urandom_range(7);
    if (bias == CFG_ALL_LOW || (bias == CFG_MIX && roll == 0)) return lo;
    if (bias == CFG_ALL_HIGH || (bias == CFG_MIX && roll == 1)) return hi;
    return $urandom_range(typ_hi, typ_lo);
  endfunction

  task automatic pick_config(input int unsigned bias);
    write_all(pick(0, 1, 0, 1, bias), pick(0, 255, 0, 255, bias),
              pick(0, 255, 0, 255, bias), pick(0, 1, 0, 1, bias),
              pick(1, 65535, 2, 60, bias), pick(0, 63, 0, 63, bias),
              pick(0, 63, 0, 24, bias), pick(0, 63, 16, 63, bias));
  endtask

  task automatic queue_item(input logic [1:0] func, input logic [7:0] pwr,
                            input logic en);
    in_t it;
    it.func         = func;
    it.rx_power     = pwr;
    it.check_enable = en;
    request_q.push_back(it);
    // ignored items do not count toward the phase length
    if (func == FUNC_POWERUP || func == FUNC_RECHECK || (func == FUNC_TICK && en))
      live_items++;
  endtask

  task automatic queue_tick_plain(input logic [7:0] pwr);
    queue_item(FUNC_TICK, pwr, 1'b1);
  endtask

  // enabled tick, sometimes preceded by a disabled tick or an unused code
  task automatic queue_tick(input logic [7:0] pwr);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6)
      queue_item(FUNC_TICK, 8'($urandom), 1'b0);
    else if (roll < 9)
      queue_item(FUNC_UNUSED, 8'($urandom), 1'($urandom));
    queue_tick_plain(pwr);
  endtask

  function automatic logic [7:0] pwr_at_least(input logic [7:0] lo);
    return 8'($urandom_range(255, lo));
  endfunction

  // nothing is below zero; fall back to any value
  function automatic logic [7:0] pwr_below(input logic [7:0] hi);
    return (hi == 8'd0) ? 8'($urandom) : 8'($urandom_range(hi - 8'd1));
  endfunction

  // A well-formed check: arm, leave idle, wait for quiet, step down, end.
  // Short step counts leave the check mid-way for the next start to cut.
  task automatic queue_check_run();
    int unsigned waits;
    int unsigned steps;
    queue_item($urandom_range(1) ? FUNC_POWERUP : FUNC_RECHECK,
               8'($urandom), 1'($urandom));
    queue_tick(8'($urandom));
    waits = $urandom_range(3);
    repeat (waits) queue_tick(pwr_at_least(regs.quiet_threshold));
    queue_tick(pwr_below(regs.quiet_threshold));
    steps = $urandom_range(regs.max_atten / 2 + 2);
    if ($urandom_range(3) == 0) steps = $urandom_range(3);
    repeat (steps) queue_tick(pwr_below(regs.limit_level));
    if ($urandom_range(1)) queue_tick(pwr_at_least(regs.limit_level));
    queue_tick(8'($urandom));
    queue_tick(8'($urandom));
  endtask

  // wait until every queued item went in and every result came back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned roll;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: odd max attenuation so the last step is by one, then ok;
    // recheck into limit with the limit-run message.
    write_all(1, 100, 200, 1, 40, 5, 0, 63);
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // armed at reset: leaves idle
    queue_item(FUNC_UNUSED, 8'hff, 1'b1);    // ignored code
    queue_item(FUNC_TICK, 8'h00, 1'b0);      // disabled; timer still counts
    queue_item(FUNC_TICK, 8'hff, 1'b1);      // too loud, keep waiting
    queue_item(FUNC_TICK, 8'd99, 1'b1);      // quiet: attenuator to 5
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // 3
    queue_item(FUNC_TICK, 8'd199, 1'b1);     // 1, just under the limit
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // 1 -> 0
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // at zero: ok
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // ok end, alarm, park
    queue_item(FUNC_TICK, 8'd0, 1'b1);       // disarmed tick
    queue_item(FUNC_RECHECK, 8'd0, 1'b0);
    queue_item(FUNC_TICK, 8'hff, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'hff, 1'b1);      // at limit inside window
    queue_item(FUNC_TICK, 8'h80, 1'b1);      // limit end
    queue_item(FUNC_POWERUP, 8'hff, 1'b0);
    wait_idle();

    // Zero timeout: fails on the tick after leaving idle
    write_all(0, 255, 0, 0, 0, 5, 10, 20);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    wait_idle();

    // Limit reached outside the attenuation window: fail
    write_all(0, 255, 0, 0, 65535, 5, 10, 20);
    queue_item(FUNC_RECHECK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    queue_item(FUNC_TICK, 8'd0, 1'b1);
    wait_idle();

    // Random phases: four per idling pattern, one all-high and one all-low
    // setting, the long hold-off in the first phase without idling.
    for (int p = 0; p < 12; p++) begin
      @(posedge clk_i);
      tx_idle_pct = (p < 4) ? 15 : (p < 8) ? 46 : 0;
      rx_idle_pct = (p < 4) ? 46 : (p < 8) ? 15 : 0;
      pick_config((p == 3) ? CFG_ALL_HIGH : (p == 7) ? CFG_ALL_LOW : CFG_MIX);
      if (p == 8) hold_go = 1'b1;
      live_items = 0;
      // a few ticks first, so a check left over from the last phase runs on
      repeat ($urandom_range(3)) queue_tick(8'($urandom));
      while (live_items < ITEMS_PER_RUN) begin
        roll = $urandom_range(9);
        if (roll < 7) begin
          queue_check_run();
        end else if (roll < 9) begin
          repeat (5) queue_item(2'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          queue_item(FUNC_RECHECK, 8'($urandom), 1'($urandom));
          repeat ($urandom_range(4)) queue_tick(8'($urandom));
        end
      end
      wait_idle();
    end

    if (status_q.size() != 0) report_mismatch("results missing", status_q.size(), 0);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
